// ----- src/opr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opr_pkg
// shared types for the optimal page replacement fault counter
// ----------------------------------------------------------------------------
package opr_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_BACK,
        ST_FWD_RD,
        ST_FWD,
        ST_EVICT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic back_start;
        logic back_step;
        logic fwd_start;
        logic fwd_read;
        logic fwd_look;
        logic evict_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic back_done;
        logic fwd_done;
        logic hit;
        logic full;
        logic evict_done;
    } t_status;

endpackage

// ----- src/opr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opr_ctrl
// sequencer for the load, clear, backward and forward passes
// ----------------------------------------------------------------------------
module opr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_last_acc,
    input  logic              i_out_free,
    input  opr_pkg::t_status  i_status,
    output opr_pkg::t_cmd     o_cmd,
    output logic              o_loading
);
    opr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= opr_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            opr_pkg::ST_LOAD:   if (i_last_acc) n_state = opr_pkg::ST_CLEAR;
            opr_pkg::ST_CLEAR:  if (i_status.clr_done) n_state = opr_pkg::ST_BACK;
            opr_pkg::ST_BACK:   if (i_status.back_done) n_state = opr_pkg::ST_FWD_RD;
            opr_pkg::ST_FWD_RD: begin
                if (i_status.fwd_done) n_state = opr_pkg::ST_DONE;
                else n_state = opr_pkg::ST_FWD;
            end
            opr_pkg::ST_FWD: begin
                if (!i_status.hit && i_status.full) n_state = opr_pkg::ST_EVICT;
                else n_state = opr_pkg::ST_FWD_RD;
            end
            opr_pkg::ST_EVICT:  if (i_status.evict_done) n_state = opr_pkg::ST_FWD_RD;
            opr_pkg::ST_DONE:   if (i_out_free) n_state = opr_pkg::ST_LOAD;
            default:            n_state = opr_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_loading = 1'b0;
        case (r_state)
            opr_pkg::ST_LOAD: begin
                o_loading = 1'b1;
                o_cmd.clr_start = i_last_acc;
            end
            opr_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.back_start = i_status.clr_done;
            end
            opr_pkg::ST_BACK: begin
                o_cmd.back_step = 1'b1;
                o_cmd.fwd_start = i_status.back_done;
            end
            opr_pkg::ST_FWD_RD: o_cmd.fwd_read = !i_status.fwd_done;
            opr_pkg::ST_FWD:    o_cmd.fwd_look = 1'b1;
            opr_pkg::ST_EVICT:  o_cmd.evict_step = 1'b1;
            opr_pkg::ST_DONE:   o_cmd.finish = i_out_free;
            default:            o_cmd = '0;
        endcase
    end
endmodule

// ----- src/opr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opr_dp
// request stores, last-seen table, cache ways and fault counter
// ----------------------------------------------------------------------------
module opr_dp #(
    parameter int MAX_REQUESTS = 1024,
    parameter int PAGE_IDS     = 1024,
    parameter int CACHE_WAYS   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  opr_pkg::t_cmd     i_cmd,
    input  logic              i_in_acc,
    input  logic [9:0]        i_page,
    input  logic [4:0]        i_cache_size,
    output opr_pkg::t_status  o_status,
    output logic [10:0]       o_fault_count,
    output logic              o_overflow
);
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 2);
    localparam int PW = (PAGE_IDS > 1) ? $clog2(PAGE_IDS) : 1;
    localparam int WW = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
    localparam int KW = $clog2(CACHE_WAYS + 1);
    localparam logic [10:0] FAULT_MAX = 11'd2047;

    logic [PW-1:0] r_req_mem  [MAX_REQUESTS];
    logic [CW-1:0] r_next_mem [MAX_REQUESTS];
    logic [CW-1:0] r_seen_mem [PAGE_IDS];

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [10:0]   r_faults;
    logic [PW-1:0] r_clr_idx;
    logic [CW-1:0] r_idx;
    logic [1:0]    r_bphase;
    logic [PW-1:0] r_pg;
    logic [CW-1:0] r_nu;
    logic [CW-1:0] r_seen_rd;
    logic [KW-1:0] r_k;

    logic [CACHE_WAYS-1:0] r_wvalid;
    logic [PW-1:0]         r_wpage [CACHE_WAYS];
    logic [CW-1:0]         r_wnu   [CACHE_WAYS];
    logic [WW-1:0]         r_scan;
    logic [WW-1:0]         r_best;

    logic [PW-1:0] w_page;
    logic [KW-1:0] w_k;
    logic [CW-1:0] w_sent;
    logic [AW-1:0] w_bidx;
    logic          w_hit;
    logic [WW-1:0] w_hit_way;
    logic          w_free;
    logic [WW-1:0] w_free_way;
    logic          w_full;

    assign w_page = PW'({22'd0, i_page} % PAGE_IDS);
    assign w_sent = r_count + CW'(1);
    assign w_bidx = AW'(r_idx - CW'(1));

    always_comb begin
        if (i_cache_size == 5'd0) w_k = KW'(1);
        else if (32'(i_cache_size) > CACHE_WAYS) w_k = KW'(CACHE_WAYS);
        else w_k = KW'(i_cache_size);
    end

    always_comb begin
        w_hit = 1'b0;
        w_hit_way = '0;
        w_free = 1'b0;
        w_free_way = '0;
        for (int w = 0; w < CACHE_WAYS; w++) begin
            if (KW'(w) < r_k) begin
                if (r_wvalid[w]) begin
                    if (r_wpage[w] == r_pg) begin
                        w_hit = 1'b1;
                        w_hit_way = WW'(w);
                    end
                end else if (!w_free) begin
                    w_free = 1'b1;
                    w_free_way = WW'(w);
                end
            end
        end
        w_full = !w_free;
    end

    assign o_status.clr_done   = (32'(r_clr_idx) == PAGE_IDS - 1);
    assign o_status.back_done  = (r_idx == '0) && (r_bphase == 2'd0);
    assign o_status.fwd_done   = (r_idx == r_count);
    assign o_status.hit        = w_hit;
    assign o_status.full       = w_full;
    assign o_status.evict_done = (KW'(r_scan) + KW'(1) >= r_k);

    // load and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_faults <= '0;
            r_k      <= KW'(1);
        end else begin
            if (i_in_acc) begin
                if (32'(r_count) < MAX_REQUESTS) r_count <= r_count + CW'(1);
                else r_ovf <= 1'b1;
            end
            if (i_cmd.clr_start) begin
                r_k <= w_k;
                r_faults <= '0;
            end
            if (i_cmd.fwd_look && !w_hit && r_faults < FAULT_MAX)
                r_faults <= r_faults + 11'd1;
            if (i_cmd.finish) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_acc && 32'(r_count) < MAX_REQUESTS)
            r_req_mem[AW'(r_count)] <= w_page;
    end

    // table clear, backward pass in three phases: read req, read seen, write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_idx     <= '0;
            r_bphase  <= 2'd0;
        end else begin
            if (i_cmd.clr_start) r_clr_idx <= '0;
            else if (i_cmd.clr_step) r_clr_idx <= r_clr_idx + PW'(1);
            if (i_cmd.back_start) begin
                r_idx <= r_count;
                r_bphase <= (r_count == '0) ? 2'd0 : 2'd1;
            end else if (i_cmd.back_step) begin
                case (r_bphase)
                    2'd1: r_bphase <= 2'd2;
                    2'd2: r_bphase <= 2'd3;
                    2'd3: begin
                        r_idx <= r_idx - CW'(1);
                        r_bphase <= (r_idx == CW'(1)) ? 2'd0 : 2'd1;
                    end
                    default: r_bphase <= 2'd0;
                endcase
            end
            if (i_cmd.fwd_start) r_idx <= '0;
            else if (i_cmd.fwd_look) r_idx <= r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_seen_mem[r_clr_idx] <= w_sent;
        if (i_cmd.back_step && r_bphase == 2'd3)
            r_seen_mem[r_pg] <= CW'(w_bidx);
        if (i_cmd.back_step && r_bphase == 2'd2) r_seen_rd <= r_seen_mem[r_pg];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.back_step && r_bphase == 2'd1) r_pg <= r_req_mem[w_bidx];
        if (i_cmd.fwd_read) begin
            r_pg <= r_req_mem[AW'(r_idx)];
            r_nu <= r_next_mem[AW'(r_idx)];
        end
        if (i_cmd.back_step && r_bphase == 2'd3) r_next_mem[w_bidx] <= r_seen_rd;
    end

    // cache ways
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_scan   <= '0;
            r_best   <= '0;
        end else begin
            if (i_cmd.fwd_start) r_wvalid <= '0;
            if (i_cmd.fwd_look) begin
                r_scan <= WW'(1);
                r_best <= '0;
                if (!w_hit && !w_full) r_wvalid[w_free_way] <= 1'b1;
            end
            if (i_cmd.evict_step) begin
                if (!o_status.evict_done) begin
                    r_scan <= r_scan + WW'(1);
                    if (r_wnu[r_scan] > r_wnu[r_best] ||
                        (r_wnu[r_scan] == r_wnu[r_best] &&
                         r_wpage[r_scan] < r_wpage[r_best]))
                        r_best <= r_scan;
                end
            end
        end
    end

    logic [WW-1:0] w_evict_way;
    always_comb begin
        w_evict_way = r_best;
        if (KW'(r_scan) < r_k &&
            (r_wnu[r_scan] > r_wnu[r_best] ||
             (r_wnu[r_scan] == r_wnu[r_best] && r_wpage[r_scan] < r_wpage[r_best])))
            w_evict_way = r_scan;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fwd_look) begin
            if (w_hit) r_wnu[w_hit_way] <= r_nu;
            else if (!w_full) begin
                r_wpage[w_free_way] <= r_pg;
                r_wnu[w_free_way] <= r_nu;
            end
        end
        if (i_cmd.evict_step && o_status.evict_done) begin
            r_wpage[w_evict_way] <= r_pg;
            r_wnu[w_evict_way] <= r_nu;
        end
    end

    assign o_fault_count = r_faults;
    assign o_overflow = r_ovf;
endmodule

// ----- src/optimal_page_replacement_faults_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optimal_page_replacement_faults_top
// optimal (farthest next use) page replacement fault counter
// ----------------------------------------------------------------------------
// requests enter on i_valid/o_ready, page and last flag, one word per
// cycle while loading; a last-marked word ends the sequence; then a clear
// sweep over all PAGE_IDS entries of the last-seen memory, a backward pass
// over the stored requests (memory read, table read, write back), and a
// forward pass that reads and looks up each request, scanning the ways
// for an eviction on each miss with a full cache, ways being cache_size
// limited to 1..CACHE_WAYS; one result word (fault count, overflow) follows
// on o_valid/i_ready once the forward pass ends and the output is free
// the result register is held until taken; the next sequence loads
// meanwhile, and its result waits until the held word has been taken
// cache_size is written on i_cfg_valid/o_cfg_ready and latched when the
// last word arrives; reset empties the block and sets cache_size to 3
// requests beyond MAX_REQUESTS are dropped and flagged
// ----------------------------------------------------------------------------
module optimal_page_replacement_faults_top #(
    parameter int MAX_REQUESTS = 1024,
    parameter int PAGE_IDS     = 1024,
    parameter int CACHE_WAYS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [9:0]  i_page,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_fault_count,
    output logic        o_overflow,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    opr_pkg::t_cmd    w_cmd;
    opr_pkg::t_status w_status;
    logic             w_loading;
    logic             w_in_acc;
    logic [4:0]       r_cache_size;
    logic             r_out_valid;
    logic [10:0]      r_out_faults;
    logic             r_out_ovf;
    logic [10:0]      w_faults;
    logic             w_ovf;

    assign o_ready     = w_loading;
    assign w_in_acc    = i_valid && w_loading;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_size <= 5'd3;
        end else if (i_cfg_valid) begin
            r_cache_size <= i_cfg_data;
        end
    end

    opr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_last_acc (w_in_acc && i_last),
        .i_out_free (!r_out_valid || i_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_loading  (w_loading)
    );

    opr_dp #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .PAGE_IDS     (PAGE_IDS),
        .CACHE_WAYS   (CACHE_WAYS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_in_acc      (w_in_acc),
        .i_page        (i_page),
        .i_cache_size  (r_cache_size),
        .o_status      (w_status),
        .o_fault_count (w_faults),
        .o_overflow    (w_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) begin
            r_out_faults <= w_faults;
            r_out_ovf    <= w_ovf;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_fault_count = r_out_faults;
    assign o_overflow    = r_out_ovf;

`ifndef SYNTHESIS
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.back_step |-> !o_ready)
        else $error("input ready during backward pass");
    a_finish_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_valid)
        else $error("result not presented");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_fault_count))
        else $error("result dropped while stalled");
`endif
endmodule
